// File: hw/rtl/dpd_pkg.sv
// shared types, constants and tables of the dual pi differential drive block
`default_nettype none
package dpd_pkg;

  localparam int ERR_W   = 10;  // signed error width
  localparam int PROD_W  = 35;  // signed gain times error
  localparam int SUM_W   = 37;  // signed working width of the pi sums
  localparam int INTEG_W = 32;  // integrator width
  localparam int SPD_W   = 11;  // signed regulator speed
  localparam int OUT_W   = 12;  // signed motor speed
  localparam int GAIN_W  = 24;
  localparam int DEG_W   = 9;
  localparam int MM_W    = 12;
  localparam int CM_W    = 9;
  localparam int LIM_W   = 10;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // mm to cm: x / 10 == (x * 52429) >> 19 for every 12-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam int ANGLE_SPEED_MAX = 1000;
  localparam int DIST_SPEED_MAX  = 8;
  localparam logic [LIM_W-1:0] DIST_INT_LIMIT = 10'd13;

  // register indexes
  typedef enum logic [2:0] {
    REG_ANGLE_KP    = 3'd0,
    REG_ANGLE_KI    = 3'd1,
    REG_ANGLE_REF   = 3'd2,
    REG_ANGLE_LIMIT = 3'd3,
    REG_DIST_KP     = 3'd4,
    REG_DIST_KI     = 3'd5,
    REG_DIST_REF    = 3'd6,
    REG_DEADBAND    = 3'd7
  } dpd_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] head_kp;
    logic [GAIN_W-1:0] head_ki;
    logic [DEG_W-1:0]  head_sp;
    logic [LIM_W-1:0]  angle_windup_limit;
    logic [GAIN_W-1:0] range_kp;
    logic [GAIN_W-1:0] range_ki;
    logic [CM_W-1:0]   range_sp;
    logic [CM_W-1:0]   deadband_cm;
  } dpd_cfg_t;

  localparam dpd_cfg_t CFG_RESET = '{
    head_kp:            24'd786432,
    head_ki:            24'd196608,
    head_sp:            9'd90,
    angle_windup_limit: 10'd13,
    range_kp:           24'd108134,
    range_ki:           24'd295,
    range_sp:           9'd10,
    deadband_cm:        9'd0
  };

  // stage enables of the front pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } dpd_adv_t;

  // products handed to the pi stage
  typedef struct packed {
    logic signed [PROD_W-1:0] ap;
    logic signed [PROD_W-1:0] adi;
    logic signed [PROD_W-1:0] dp;
    logic signed [PROD_W-1:0] ddi;
    logic                     hold;
  } dpd_gain_t;

  // |d| * 1000 / 13 truncated, for |d| up to the distance speed bound
  function automatic logic [9:0] steps_of(input logic [3:0] mag);
    logic [9:0] r;
    case (mag)
      4'd1:    r = 10'd76;
      4'd2:    r = 10'd153;
      4'd3:    r = 10'd230;
      4'd4:    r = 10'd307;
      4'd5:    r = 10'd384;
      4'd6:    r = 10'd461;
      4'd7:    r = 10'd538;
      4'd8:    r = 10'd615;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/dual_pi_differential_drive.sv
// top level of the dual pi differential drive controller
// how to use this block:
// - in_*: one beat per control tick; in_tdata holds angle_deg (bits 8:0, degrees)
//   and distance_mm (bits 20:9, millimetres)
// - out_*: one beat per input beat; out_tdata holds right_speed (bits 11:0) and
//   left_speed (bits 23:12), both two's complement steps per second
// - cfg_*: apb register port, register i at byte address 4*i; write the gains,
//   references, angle windup limit and deadband only while no beat is in flight
// - path: a result passes through an input register, an error stage, a gain
//   product stage, the pi stage and the output register
// - throughput: one beat per cycle while out_tready stays high; both integrator
//   updates loop within the pi stage, so back to back beats never wait on them
// - stall: each stage moves on when the stage after it is empty or moving, so
//   while the receiver holds out_tready low the pipe keeps filling its empty
//   stages; in_tready drops only once all five stages hold a beat
// - reset: synchronous, active low; registers return to their reset values, both
//   integrators clear and the pipe empties
`default_nettype none
module dual_pi_differential_drive #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,     // angle_deg, distance_mm
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,    // right_speed, left_speed
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import dpd_pkg::*;

  dpd_cfg_t  cfg;
  dpd_adv_t  adv;
  dpd_gain_t gain;

  // beat valid of each stage
  logic v1_r, v2_r, v3_r, v4_r, ov_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;

  logic signed [SPD_W-1:0] a_spd, d_spd_raw, d_spd;
  logic signed [SPD_W-1:0] a_spd_r, d_spd_r;
  logic        [SPD_W-1:0] d_abs;
  logic signed [OUT_W-1:0] d_mix, right_nxt, left_nxt;
  logic        [23:0]      out_data_r;

  assign cfg_pready = 1'b1;

  dpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // ready ripples back from the output register
  assign rdy_o = !ov_r || out_tready;
  assign rdy4  = !v4_r || rdy_o;
  assign rdy3  = !v3_r || rdy4;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign adv.s1 = in_tvalid && rdy1;
  assign adv.s2 = v1_r && rdy2;
  assign adv.s3 = v2_r && rdy3;

  dpd_front u_front (
    .clk         (clk),
    .adv         (adv),
    .angle_deg   (in_tdata[DEG_W-1:0]),
    .distance_mm (in_tdata[DEG_W+MM_W-1:DEG_W]),
    .cfg         (cfg),
    .gain        (gain)
  );

  // both integrators step when the product stage hands its beat on, the distance one only outside the deadband
  dpd_pi_core #(
    .FRAC_BITS (GAIN_FRAC_BITS),
    .SPEED_MAX (ANGLE_SPEED_MAX)
  ) u_pi_angle (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (v3_r && rdy4),
    .p     (gain.ap),
    .di    (gain.adi),
    .limit (cfg.angle_windup_limit),
    .speed (a_spd)
  );

  // inside the deadband the distance integrator holds
  dpd_pi_core #(
    .FRAC_BITS (GAIN_FRAC_BITS),
    .SPEED_MAX (DIST_SPEED_MAX)
  ) u_pi_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (v3_r && rdy4 && !gain.hold),
    .p     (gain.dp),
    .di    (gain.ddi),
    .limit (DIST_INT_LIMIT),
    .speed (d_spd_raw)
  );

  assign d_spd = gain.hold ? '0 : d_spd_raw;

  // distance speed to steps per second, then the differential mix
  assign d_abs     = d_spd_r[SPD_W-1] ? SPD_W'(-d_spd_r) : SPD_W'(d_spd_r);
  assign d_mix     = d_spd_r[SPD_W-1] ? -OUT_W'({1'b0, steps_of(d_abs[3:0])})
                                      : OUT_W'({1'b0, steps_of(d_abs[3:0])});
  assign right_nxt = d_mix + OUT_W'(a_spd_r);
  assign left_nxt  = d_mix - OUT_W'(a_spd_r);

  assign out_tvalid = ov_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1)  v1_r <= in_tvalid;
      if (rdy2)  v2_r <= v1_r;
      if (rdy3)  v3_r <= v2_r;
      if (rdy4)  v4_r <= v3_r;
      if (rdy_o) ov_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && rdy4) begin
      a_spd_r <= a_spd;
      d_spd_r <= d_spd;
    end
    if (v4_r && rdy_o) begin
      out_data_r <= {left_nxt, right_nxt};
    end
  end

  // regulator speeds stay inside their clamps
  a_spd_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (a_spd_r <= 11'sd1000) && (a_spd_r >= -11'sd1000))
    else $error("angle speed outside its clamp");

  d_spd_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (d_spd_r <= 11'sd8) && (d_spd_r >= -11'sd8))
    else $error("distance speed outside its clamp");

  // mixed speeds never exceed the angle clamp plus the steps of the distance clamp
  out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[11:0]) <= 12'sd1615)
                && ($signed(out_tdata[11:0]) >= -12'sd1615)
                && ($signed(out_tdata[23:12]) <= 12'sd1615)
                && ($signed(out_tdata[23:12]) >= -12'sd1615))
    else $error("motor speed out of range");

  // input backpressure only when every stage holds a beat
  full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v1_r && v2_r && v3_r && v4_r && ov_r && !out_tready)
    else $error("input stalled with room in the pipe");

endmodule
`default_nettype wire

// File: hw/rtl/dpd_cfg.sv
// apb register file of the dual pi differential drive block
`default_nettype none
module dpd_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [dpd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [dpd_pkg::DATA_W-1:0] pwdata,
  output logic      [dpd_pkg::DATA_W-1:0] prdata,
  output dpd_pkg::dpd_cfg_t               cfg
);
  import dpd_pkg::*;

  dpd_cfg_t cfg_r;
  dpd_cfg_t cfg_nxt;
  dpd_reg_t sel;

  assign sel = dpd_reg_t'(paddr[ADDR_W-1:2]);
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (sel)
        REG_ANGLE_KP:    cfg_nxt.head_kp            = pwdata[GAIN_W-1:0];
        REG_ANGLE_KI:    cfg_nxt.head_ki            = pwdata[GAIN_W-1:0];
        REG_ANGLE_REF:   cfg_nxt.head_sp            = pwdata[DEG_W-1:0];
        REG_ANGLE_LIMIT: cfg_nxt.angle_windup_limit = pwdata[LIM_W-1:0];
        REG_DIST_KP:     cfg_nxt.range_kp           = pwdata[GAIN_W-1:0];
        REG_DIST_KI:     cfg_nxt.range_ki           = pwdata[GAIN_W-1:0];
        REG_DIST_REF:    cfg_nxt.range_sp           = pwdata[CM_W-1:0];
        REG_DEADBAND:    cfg_nxt.deadband_cm        = pwdata[CM_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_ANGLE_KP:    prdata = DATA_W'(cfg_r.head_kp);
      REG_ANGLE_KI:    prdata = DATA_W'(cfg_r.head_ki);
      REG_ANGLE_REF:   prdata = DATA_W'(cfg_r.head_sp);
      REG_ANGLE_LIMIT: prdata = DATA_W'(cfg_r.angle_windup_limit);
      REG_DIST_KP:     prdata = DATA_W'(cfg_r.range_kp);
      REG_DIST_KI:     prdata = DATA_W'(cfg_r.range_ki);
      REG_DIST_REF:    prdata = DATA_W'(cfg_r.range_sp);
      REG_DEADBAND:    prdata = DATA_W'(cfg_r.deadband_cm);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dpd_front.sv
// input register, error stage and gain product stage
`default_nettype none
module dpd_front (
  input  wire logic                      clk,
  input  wire dpd_pkg::dpd_adv_t         adv,
  input  wire logic [dpd_pkg::DEG_W-1:0] angle_deg,
  input  wire logic [dpd_pkg::MM_W-1:0]  distance_mm,
  input  wire dpd_pkg::dpd_cfg_t         cfg,
  output dpd_pkg::dpd_gain_t             gain
);
  import dpd_pkg::*;

  logic [DEG_W-1:0]        ang_r;
  logic [MM_W-1:0]         mm_r;
  logic [MM_W+15:0]        cm_prod;
  logic [CM_W-1:0]         cm;
  logic signed [ERR_W-1:0] a_err_nxt, a_err_r;
  logic signed [ERR_W-1:0] d_err_nxt, d_err_r;
  logic [ERR_W-1:0]        d_abs;
  dpd_gain_t               gain_nxt, gain_r;

  // stage 1 -> 2: mm to cm and both errors
  assign cm_prod   = mm_r * DIV10_MUL;
  assign cm        = cm_prod[DIV10_SHIFT+CM_W-1:DIV10_SHIFT];
  assign a_err_nxt = ERR_W'({1'b0, ang_r}) - ERR_W'({1'b0, cfg.head_sp});
  assign d_err_nxt = ERR_W'({1'b0, cm}) - ERR_W'({1'b0, cfg.range_sp});

  // stage 2 -> 3: gain products and deadband test
  assign d_abs = d_err_r[ERR_W-1] ? ERR_W'(-d_err_r) : ERR_W'(d_err_r);

  always_comb begin
    gain_nxt.ap   = $signed({1'b0, cfg.head_kp}) * a_err_r;
    gain_nxt.adi  = $signed({1'b0, cfg.head_ki}) * a_err_r;
    gain_nxt.dp   = $signed({1'b0, cfg.range_kp}) * d_err_r;
    gain_nxt.ddi  = $signed({1'b0, cfg.range_ki}) * d_err_r;
    gain_nxt.hold = d_abs < ERR_W'({1'b0, cfg.deadband_cm});
  end

  assign gain = gain_r;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      ang_r <= angle_deg;
      mm_r  <= distance_mm;
    end
    if (adv.s2) begin
      a_err_r <= a_err_nxt;
      d_err_r <= d_err_nxt;
    end
    if (adv.s3) begin
      gain_r <= gain_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dpd_pi_core.sv
// one pi regulator: integrator with conditional integration and speed clamp
`default_nettype none
module dpd_pi_core #(
  parameter int FRAC_BITS = 16,
  parameter int SPEED_MAX = 1000
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              upd,
  input  wire logic signed [dpd_pkg::PROD_W-1:0] p,
  input  wire logic signed [dpd_pkg::PROD_W-1:0] di,
  input  wire logic        [dpd_pkg::LIM_W-1:0]  limit,
  output logic signed      [dpd_pkg::SPD_W-1:0]  speed
);
  import dpd_pkg::*;

  localparam logic signed [SUM_W-1:0] I_MAX = {{(SUM_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] I_MIN = {{(SUM_W-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}};

  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [SUM_W-1:0]   p_w, di_w, i_w, sum3, inc, inc_c, s;
  logic        [SUM_W-1:0]   sum_abs, bound, s_abs, mag;
  logic        [SPD_W-2:0]   mag_c;
  logic                      ok;

  assign p_w  = SUM_W'(p);
  assign di_w = SUM_W'(di);
  assign i_w  = SUM_W'(integ_r);

  // integrate only while the whole pi output stays inside the bound
  assign sum3    = p_w + i_w + di_w;
  assign sum_abs = sum3[SUM_W-1] ? SUM_W'(-sum3) : SUM_W'(sum3);
  assign bound   = {{(SUM_W-LIM_W){1'b0}}, limit} << FRAC_BITS;
  assign ok      = sum_abs <= bound;

  assign inc = i_w + di_w;
  always_comb begin
    if (inc > I_MAX) begin
      inc_c = I_MAX;
    end else if (inc < I_MIN) begin
      inc_c = I_MIN;
    end else begin
      inc_c = inc;
    end
  end

  assign integ_nxt = ok ? inc_c[INTEG_W-1:0] : integ_r;

  // speed from the updated integrator, truncated toward zero
  assign s     = p_w + SUM_W'(integ_nxt);
  assign s_abs = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
  assign mag   = s_abs >> FRAC_BITS;
  assign mag_c = (mag > SUM_W'(SPEED_MAX)) ? (SPD_W-1)'(SPEED_MAX) : mag[SPD_W-2:0];
  assign speed = s[SUM_W-1] ? -SPD_W'({1'b0, mag_c}) : SPD_W'({1'b0, mag_c});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (upd) begin
      integ_r <= integ_nxt;
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/dpd_speed_checker.sv
// checker: predicts the motor speed pair of every control tick and compares it
module dpd_speed_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,     // angle_deg, distance_mm, zero pad
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,    // right_speed, left_speed
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               mismatches,
  output int               outstanding,
  output int               checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import dpd_pkg::*;

  localparam int     FRAC        = 16;
  localparam longint INTEG_MIN   = -64'sd2147483648;
  localparam longint INTEG_MAX   = 64'sd2147483647;
  localparam longint ANGLE_CLAMP = 1000;
  localparam longint DIST_CLAMP  = 8;
  localparam longint DIST_LIMIT  = 13;
  localparam longint STEP_NUM    = 1000;
  localparam longint STEP_DEN    = 13;

  typedef struct packed {
    logic signed [11:0] left;
    logic signed [11:0] right;
  } speeds_t;

  typedef struct {
    longint speed;
    longint integ;
  } pi_result_t;

  // local copy of the register file and the two integrators
  logic [23:0] head_kp, head_ki, range_kp, range_ki;
  logic [8:0]  head_sp, range_sp, deadband_cm;
  logic [9:0]  angle_limit;
  longint      angle_integ, dist_integ;

  speeds_t speed_q[$];

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one regulator: conditional integration, truncation toward zero, clamp
  function automatic pi_result_t pi_regulate(input longint err, input longint kp,
                                             input longint ki, input longint limit,
                                             input longint smax, input longint integ);
    pi_result_t r;
    longint p, di, total, mag;
    p = kp * err;
    di = ki * err;
    total = p + integ + di;
    r.integ = integ;
    if (((total < 0) ? -total : total) <= (limit << FRAC))
      r.integ = clamp(integ + di, INTEG_MIN, INTEG_MAX);
    total = p + r.integ;
    mag = ((total < 0) ? -total : total) >> FRAC;
    r.speed = clamp((total < 0) ? -mag : mag, -smax, smax);
    return r;
  endfunction

  function automatic speeds_t predict_tick(input logic [23:0] beat);
    longint angle, cm, a_sp, d_sp, band, a_err, d_err, d_speed, motion, sum;
    pi_result_t ar, dr;
    speeds_t s;
    angle = beat[8:0];
    cm = beat[20:9] / 10;
    a_sp = head_sp;
    d_sp = range_sp;
    band = deadband_cm;
    a_err = angle - a_sp;
    d_err = cm - d_sp;
    ar = pi_regulate(a_err, longint'(head_kp), longint'(head_ki),
                     longint'(angle_limit), ANGLE_CLAMP, angle_integ);
    angle_integ = ar.integ;
    if (((d_err < 0) ? -d_err : d_err) < band) begin
      d_speed = 0;
    end else begin
      dr = pi_regulate(d_err, longint'(range_kp), longint'(range_ki),
                       DIST_LIMIT, DIST_CLAMP, dist_integ);
      dist_integ = dr.integ;
      d_speed = dr.speed;
    end
    motion = d_speed * STEP_NUM / STEP_DEN;
    sum = motion + ar.speed;
    s.right = sum[11:0];
    sum = motion - ar.speed;
    s.left = sum[11:0];
    return s;
  endfunction

  always @(posedge clk) begin : watch
    speeds_t got, want;
    if (!rst_n) begin
      head_kp      = 24'd786432;
      head_ki      = 24'd196608;
      head_sp      = 9'd90;
      angle_limit  = 10'd13;
      range_kp     = 24'd108134;
      range_ki     = 24'd295;
      range_sp     = 9'd10;
      deadband_cm  = 9'd0;
      angle_integ  = 0;
      dist_integ   = 0;
      speed_q.delete();
      mismatches   = 0;
      outstanding  = 0;
      checked      = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (dpd_reg_t'(cfg_paddr[4:2]))
          REG_ANGLE_KP:    head_kp = cfg_pwdata[23:0];
          REG_ANGLE_KI:    head_ki = cfg_pwdata[23:0];
          REG_ANGLE_REF:   head_sp = cfg_pwdata[8:0];
          REG_ANGLE_LIMIT: angle_limit = cfg_pwdata[9:0];
          REG_DIST_KP:     range_kp = cfg_pwdata[23:0];
          REG_DIST_KI:     range_ki = cfg_pwdata[23:0];
          REG_DIST_REF:    range_sp = cfg_pwdata[8:0];
          REG_DEADBAND:    deadband_cm = cfg_pwdata[8:0];
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (speed_q.size() == 0) begin
          $display("%0t: result beat %h arrived, expected none", $time, out_tdata);
          mismatches++;
        end else begin
          want = speed_q.pop_front();
          checked++;
          if (got.right !== want.right) begin
            $display("%0t: right_speed expected %0d, actual %0d", $time, want.right, got.right);
            mismatches++;
          end
          if (got.left !== want.left) begin
            $display("%0t: left_speed expected %0d, actual %0d", $time, want.left, got.left);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        speed_q.push_back(predict_tick(in_tdata));
      outstanding = speed_q.size();
    end
  end

endmodule

// File: tb/sv/tb_dual_pi_differential_drive.sv
// testbench top: drives control ticks and register writes, gives the verdict
module tb_dual_pi_differential_drive;
  timeunit 1ns;
  timeprecision 1ps;
  import dpd_pkg::*;

  localparam int TICKS_PER_SETTING = 232;
  localparam int SETTLE_CYCLES     = 8;     // margin over the pipe latency
  localparam int STALL_LIMIT       = 1000;  // cycles with no beat or register access at all
  localparam int NUM_SETTINGS      = 7;

  typedef enum int {
    SET_TYPICAL,
    SET_ZERO,
    SET_MAX,
    SET_RESET_VALUES,
    SET_WILD
  } setting_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // angle_deg, distance_mm, zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // right_speed, left_speed
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches, outstanding, checked;

  bit idle_on = 1'b0;       // random gaps on both sides when set
  int hold_left = 0;        // remaining stall cycles of the receiver
  int quiet_cycles = 0;
  int beats_sent = 0;
  int settings_used = 0;
  // current references, used to aim stimulus at the regulators' working range
  int angle_target = 90;
  int range_target = 10;

  always #5 clk = ~clk;

  dual_pi_differential_drive dut (.*);

  dpd_speed_checker speed_check (.*);

  // receiver: stalls in random bursts while idling is on
  always @(posedge clk) begin
    if (!idle_on) begin
      hold_left = 0;
      out_tready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog: any accepted beat or register access restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // apb write: setup cycle, access cycle until pready, then the bus goes idle
  task automatic write_reg(input dpd_reg_t idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    if (idx == REG_ANGLE_REF) angle_target = value[8:0];
    if (idx == REG_DIST_REF) range_target = value[8:0];
  endtask

  // one input beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_beat(input logic [8:0] angle, input logic [11:0] mm);
    in_tdata <= {3'b000, mm, angle};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // mostly ticks near both references so the anti-windup test flips often,
  // the rest anywhere in the field ranges, out-of-range angles included
  task automatic send_random_tick();
    int a, cm, mm;
    if ($urandom_range(0, 9) < 6) begin
      a = (angle_target + int'($urandom_range(0, 24)) - 12) & 'h1FF;
      cm = range_target + int'($urandom_range(0, 30)) - 15;
      if (cm < 0) cm = 0;
      mm = cm * 10 + int'($urandom_range(0, 9));
      if (mm > 4095) mm = 4095;
    end else begin
      a = $urandom_range(0, 511);
      mm = $urandom_range(0, 4095);
    end
    send_beat(a[8:0], mm[11:0]);
  endtask

  // stop sending, wait for every expected result, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // rewrite the whole register file; integrators carry over on purpose
  task automatic apply_setting(input setting_t s);
    logic [31:0] v [8];
    case (s)
      SET_TYPICAL: begin
        v[REG_ANGLE_KP]    = $urandom_range(0, 32'h1F_FFFF);
        v[REG_ANGLE_KI]    = $urandom_range(0, 32'h7_FFFF);
        v[REG_ANGLE_REF]   = $urandom_range(0, 359);
        v[REG_ANGLE_LIMIT] = $urandom_range(0, 1000);
        v[REG_DIST_KP]     = $urandom_range(0, 32'h3_FFFF);
        v[REG_DIST_KI]     = $urandom_range(0, 32'h3FFF);
        v[REG_DIST_REF]    = $urandom_range(0, 409);
        v[REG_DEADBAND]    = $urandom_range(0, 12);
      end
      SET_ZERO: begin
        foreach (v[i]) v[i] = '0;
      end
      SET_MAX: begin
        v[REG_ANGLE_KP]    = 32'hFF_FFFF;
        v[REG_ANGLE_KI]    = 32'hFF_FFFF;
        v[REG_ANGLE_REF]   = 32'h1FF;
        v[REG_ANGLE_LIMIT] = 32'h3FF;
        v[REG_DIST_KP]     = 32'hFF_FFFF;
        v[REG_DIST_KI]     = 32'hFF_FFFF;
        v[REG_DIST_REF]    = 32'h1FF;
        v[REG_DEADBAND]    = 32'h1FF;
      end
      SET_RESET_VALUES: begin
        v[REG_ANGLE_KP]    = 32'd786432;
        v[REG_ANGLE_KI]    = 32'd196608;
        v[REG_ANGLE_REF]   = 32'd90;
        v[REG_ANGLE_LIMIT] = 32'd13;
        v[REG_DIST_KP]     = 32'd108134;
        v[REG_DIST_KI]     = 32'd295;
        v[REG_DIST_REF]    = 32'd10;
        v[REG_DEADBAND]    = 32'd0;
      end
      default: begin
        // anything the register widths allow, but the deadband only up to 31
        v[REG_ANGLE_KP]    = $urandom & 32'hFF_FFFF;
        v[REG_ANGLE_KI]    = $urandom & 32'hFF_FFFF;
        v[REG_ANGLE_REF]   = $urandom & 32'h1FF;
        v[REG_ANGLE_LIMIT] = $urandom & 32'h3FF;
        v[REG_DIST_KP]     = $urandom & 32'hFF_FFFF;
        v[REG_DIST_KI]     = $urandom & 32'hFF_FFFF;
        v[REG_DIST_REF]    = $urandom & 32'h1FF;
        v[REG_DEADBAND]    = $urandom & 32'h1F;
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(dpd_reg_t'(i), v[i]);
    settings_used++;
  endtask

  initial begin
    setting_t plan [NUM_SETTINGS];
    plan = '{SET_TYPICAL, SET_ZERO, SET_MAX, SET_TYPICAL, SET_WILD,
             SET_RESET_VALUES, SET_TYPICAL};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks at the reset settings: zero error, field extremes,
    // out-of-range angles, mm values on both sides of a whole cm
    send_beat(9'd90, 12'd100);
    send_beat(9'd0, 12'd0);
    send_beat(9'd359, 12'd4095);
    send_beat(9'd511, 12'd4095);
    send_beat(9'd511, 12'd0);
    send_beat(9'd0, 12'd4095);
    send_beat(9'd91, 12'd109);
    send_beat(9'd89, 12'd110);
    send_beat(9'd92, 12'd99);
    send_beat(9'd90, 12'd4095);
    send_beat(9'd360, 12'd100);
    send_beat(9'd256, 12'd2048);
    send_beat(9'd170, 12'd1000);
    send_beat(9'd10, 12'd1);
    send_beat(9'd90, 12'd105);
    send_beat(9'd88, 12'd95);
    drain();

    // deadband of 5 cm around the 10 cm reference: inside, on the edge, far out
    write_reg(REG_DEADBAND, 32'd5);
    settings_used++;
    send_beat(9'd90, 12'd100);
    send_beat(9'd91, 12'd140);
    send_beat(9'd92, 12'd149);
    send_beat(9'd90, 12'd150);
    send_beat(9'd89, 12'd59);
    send_beat(9'd88, 12'd60);
    send_beat(9'd90, 12'd4095);
    send_beat(9'd90, 12'd0);
    drain();

    // random phases; the last one runs with no idling at all
    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      apply_setting(plan[ph]);
      for (int n = 0; n < TICKS_PER_SETTING; n++) begin
        if (n % 40 == 0)
          idle_on = (ph != NUM_SETTINGS - 1) && ($urandom_range(0, 3) != 0);
        send_random_tick();
      end
      drain();
    end

    $display("covered %0d control ticks over %0d register settings", beats_sent,
             settings_used);
    $display("(zero, full-scale, reset, random and deadband), %0d speed pairs checked",
             checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
